### rtl/kmeans_pkg.sv
// Package: shared types and codes for the 1-D k-means block.
package kmeans_pkg;
  localparam int CMD_BITS = 3;
  localparam logic [2:0] CMD_LOAD_POINT = 3'd0;
  localparam logic [2:0] CMD_LOAD_CENT  = 3'd1;
  localparam logic [2:0] CMD_RUN        = 3'd2;
  localparam logic [2:0] CMD_READ_MEMB  = 3'd3;
  localparam logic [2:0] CMD_READ_CENT  = 3'd4;
  localparam logic [2:0] CMD_CLEAR      = 3'd5;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_MEMB = 2'd1;
  localparam logic [1:0] KIND_CENT = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  localparam logic CFG_CLUSTERS = 1'b0;
  localparam logic CFG_ITERS    = 1'b1;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [9:0]         slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] data;
    logic [9:0]         iterations;
    logic               converged;
    logic [1:0]         error_code;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

### rtl/kmeans_div.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module kmeans_div #(
  parameter int NUM_BITS = 42,
  parameter int DEN_BITS = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                busy,
  output logic                done,
  output logic [NUM_BITS-1:0] quo
);
  import kmeans_pkg::*;
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] q_r, q_nxt;
  logic [DEN_BITS:0]   rem_r, rem_nxt;
  logic [DEN_BITS-1:0] den_r;
  logic                neg_r;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                busy_r, done_r;
  logic [DEN_BITS:0]   trial;

  always_comb begin
    trial   = {rem_r[DEN_BITS-1:0], q_r[NUM_BITS-1]};
    rem_nxt = trial;
    q_nxt   = {q_r[NUM_BITS-2:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt  = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
    cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(NUM_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_nxt;
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[NUM_BITS-1] ? (~num + 1'b1) : num;
      neg_r <= num[NUM_BITS-1];
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = neg_r ? (~q_r + 1'b1) : q_r;
endmodule

### rtl/one_d_kmeans_clustering.sv
// Top level: command-driven 1-D Lloyd k-means engine with a shared sequencer.
//
// Usage: drive in_item with start while busy is low; an item is taken at the
// edge where start is high and busy is low. Loads, clears and centroid reads
// never raise busy, so the next item can follow in the next cycle. A centroid
// read, and any error item, shows up in the cycle after acceptance. A
// membership read holds busy through S_RDM and S_RDM2 and returns its item
// in the cycle after that. A result appears on out_item for exactly one cycle
// with out_valid high and cannot be stalled; hold nothing downstream.
// A run holds busy for its whole length. Each iteration runs the assign pass
// (read a point, one distance compare per centroid, write the membership, for
// each point), then the update pass (clear sums, then read and accumulate each
// point in turn), then the mean step (the bit-serial divider for each non-empty
// cluster, 0 for each empty one), and S_NEXT closes the iteration. S_FIN
// follows the last iteration, and the run-finished item comes in the cycle
// after it. Iterations repeat until memberships are unchanged after the first
// iteration or the iteration limit is reached. The point and membership stores
// are simple dual-port memories.
// Read memberships only of points that a run has assigned since they were
// loaded; other entries hold stale or undefined values.
module one_d_kmeans_clustering #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 16,
  parameter int VALUE_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  kmeans_pkg::in_item_t  in_item,
  output logic                  out_valid,
  output kmeans_pkg::out_item_t out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [9:0]            cfg_data
);
  import kmeans_pkg::*;

  localparam int PA = $clog2(MAX_POINTS);
  localparam int PC = $clog2(MAX_POINTS + 1);
  localparam int CA = $clog2(MAX_CLUSTERS);
  localparam int CC = $clog2(MAX_CLUSTERS + 1);
  localparam int SB = VALUE_BITS + PC;

  localparam logic [3:0] S_IDLE = 4'd0, S_RDM = 4'd1, S_RDM2 = 4'd2,
    S_A_RD = 4'd3, S_A_CMP = 4'd4, S_A_WR = 4'd5, S_U_CLR = 4'd6,
    S_U_RD = 4'd7, S_U_ACC = 4'd8, S_D_GO = 4'd9, S_D_WAIT = 4'd10,
    S_NEXT = 4'd11, S_FIN = 4'd12;

  logic [3:0] st_r;
  logic [4:0] kcfg_r;
  logic [9:0] lim_r;
  logic [PC-1:0] total_r;
  logic [9:0] last_it_r, it_r;
  logic last_conv_r, same_r;
  logic signed [VALUE_BITS-1:0] cent_r [MAX_CLUSTERS];
  logic signed [SB-1:0] sum_r [MAX_CLUSTERS];
  logic [PC-1:0] size_r [MAX_CLUSTERS];
  logic signed [VALUE_BITS-1:0] pmem [MAX_POINTS];
  logic [CA-1:0] mmem [MAX_POINTS];
  logic signed [VALUE_BITS-1:0] pt_r;
  logic [CA-1:0] mrd_r, best_r;
  logic [PA-1:0] pi_r;
  logic [CA-1:0] ci_r;
  logic [VALUE_BITS:0] best_d_r;
  logic [CC-1:0] keff;
  logic [9:0] leff;
  out_item_t res_r;
  logic res_v_r;

  // Clamp cluster count and limit the same way on every run.
  always_comb begin
    if (kcfg_r == 5'd0) keff = CC'(1);
    else if ({27'd0, kcfg_r} > MAX_CLUSTERS) keff = CC'(MAX_CLUSTERS);
    else keff = CC'(kcfg_r);
    leff = (lim_r == 10'd0) ? 10'd1 : lim_r;
  end

  // Shared distance unit.
  logic signed [VALUE_BITS:0] diff;
  logic [VALUE_BITS:0] pt_dist;
  assign diff = {cent_r[ci_r][VALUE_BITS-1], cent_r[ci_r]} - {pt_r[VALUE_BITS-1], pt_r};
  assign pt_dist = diff[VALUE_BITS] ? (VALUE_BITS+1)'(0) - diff : diff;

  // Divider for the means.
  logic d_start, d_busy, d_done;
  logic [SB-1:0] d_quo;
  kmeans_div #(.NUM_BITS(SB), .DEN_BITS(PC)) u_div (
    .clk(clk), .rst_n(rst_n), .start(d_start), .num(sum_r[ci_r]),
    .den(size_r[ci_r]), .busy(d_busy), .done(d_done), .quo(d_quo));
  assign d_start = (st_r == S_D_GO) && (size_r[ci_r] != '0);

  logic signed [VALUE_BITS-1:0] vin;
  assign vin = VALUE_BITS'(in_item.value);
  logic go;
  assign go = start && (st_r == S_IDLE);
  assign busy = (st_r != S_IDLE);
  // Take register writes only while no item is being accepted or worked on.
  assign cfg_ready = (st_r == S_IDLE) && !start;

  function automatic out_item_t mk(input logic [1:0] k, input logic [31:0] d,
      input logic [1:0] e, input logic [9:0] it, input logic cv);
    out_item_t o;
    o.kind = k; o.data = d; o.error_code = e; o.iterations = it; o.converged = cv;
    return o;
  endfunction

  // Memories.
  always_ff @(posedge clk) begin
    if (go && in_item.command == CMD_LOAD_POINT && total_r < PC'(MAX_POINTS))
      pmem[total_r[PA-1:0]] <= vin;
    pt_r <= pmem[pi_r];
  end
  always_ff @(posedge clk) begin
    if (st_r == S_A_WR) mmem[pi_r] <= best_r;
    mrd_r <= mmem[pi_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; kcfg_r <= 5'd2; lim_r <= 10'd255; total_r <= '0;
      last_it_r <= '0; last_conv_r <= 1'b0; res_v_r <= 1'b0;
      it_r <= '0; same_r <= 1'b0; pi_r <= '0; ci_r <= '0;
      for (int j = 0; j < MAX_CLUSTERS; j++) begin
        cent_r[j] <= '0; sum_r[j] <= '0; size_r[j] <= '0;
      end
    end else begin
      res_v_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CLUSTERS) kcfg_r <= cfg_data[4:0];
        else lim_r <= cfg_data;
      end
      unique case (st_r)
        S_IDLE: if (go) begin
          case (in_item.command)
            CMD_LOAD_POINT:
              if (total_r < PC'(MAX_POINTS)) total_r <= total_r + 1'b1;
              else begin
                res_r <= mk(KIND_ERR, '0, ERR_FULL, last_it_r, last_conv_r);
                res_v_r <= 1'b1;
              end
            CMD_LOAD_CENT:
              if (in_item.slot < 10'(MAX_CLUSTERS)) cent_r[in_item.slot[CA-1:0]] <= vin;
              else begin
                res_r <= mk(KIND_ERR, '0, ERR_RANGE, last_it_r, last_conv_r);
                res_v_r <= 1'b1;
              end
            CMD_READ_CENT: begin
              if (in_item.slot < 10'(MAX_CLUSTERS))
                res_r <= mk(KIND_CENT, 32'(cent_r[in_item.slot[CA-1:0]]), ERR_NONE,
                            last_it_r, last_conv_r);
              else res_r <= mk(KIND_ERR, '0, ERR_RANGE, last_it_r, last_conv_r);
              res_v_r <= 1'b1;
            end
            CMD_READ_MEMB:
              if (32'(in_item.slot) < 32'(total_r)) begin
                pi_r <= in_item.slot[PA-1:0];
                st_r <= S_RDM;
              end else begin
                res_r <= mk(KIND_ERR, '0, ERR_RANGE, last_it_r, last_conv_r);
                res_v_r <= 1'b1;
              end
            CMD_RUN: begin
              it_r <= '0; same_r <= 1'b1; pi_r <= '0; ci_r <= '0;
              st_r <= (total_r == '0) ? S_U_CLR : S_A_RD;
            end
            CMD_CLEAR: total_r <= '0;
            default: ;
          endcase
        end
        S_RDM: st_r <= S_RDM2;
        S_RDM2: begin
          res_r <= mk(KIND_MEMB, 32'(mrd_r), ERR_NONE, last_it_r, last_conv_r);
          res_v_r <= 1'b1;
          st_r <= S_IDLE;
        end
        // Wait for point and old membership reads.
        S_A_RD: begin
          ci_r <= '0;
          st_r <= S_A_CMP;
        end
        S_A_CMP: begin
          if (ci_r == '0 || pt_dist < best_d_r) begin
            best_d_r <= pt_dist; best_r <= ci_r;
          end
          if (CC'(ci_r) == keff - 1'b1) st_r <= S_A_WR;
          else ci_r <= ci_r + 1'b1;
        end
        S_A_WR: begin
          if (best_r != mrd_r) same_r <= 1'b0;
          if (PC'(pi_r) == total_r - 1'b1) begin
            pi_r <= '0; st_r <= S_U_CLR;
          end else begin
            pi_r <= pi_r + 1'b1; st_r <= S_A_RD;
          end
        end
        S_U_CLR: begin
          for (int j = 0; j < MAX_CLUSTERS; j++)
            if (CC'(j) < keff) begin sum_r[j] <= '0; size_r[j] <= '0; end
          st_r <= (total_r == '0) ? S_D_GO : S_U_RD;
          ci_r <= '0;
        end
        S_U_RD: st_r <= S_U_ACC;
        S_U_ACC: begin
          sum_r[mrd_r] <= sum_r[mrd_r] + SB'(pt_r);
          size_r[mrd_r] <= size_r[mrd_r] + 1'b1;
          if (PC'(pi_r) == total_r - 1'b1) begin
            pi_r <= '0; ci_r <= '0; st_r <= S_D_GO;
          end else begin
            pi_r <= pi_r + 1'b1; st_r <= S_U_RD;
          end
        end
        S_D_GO: begin
          if (size_r[ci_r] == '0) begin
            cent_r[ci_r] <= '0;
            if (CC'(ci_r) == keff - 1'b1) st_r <= S_NEXT;
            else ci_r <= ci_r + 1'b1;
          end else st_r <= S_D_WAIT;
        end
        S_D_WAIT: if (d_done) begin
          cent_r[ci_r] <= d_quo[VALUE_BITS-1:0];
          if (CC'(ci_r) == keff - 1'b1) st_r <= S_NEXT;
          else begin ci_r <= ci_r + 1'b1; st_r <= S_D_GO; end
        end
        S_NEXT: begin
          it_r <= it_r + 1'b1;
          if ((same_r && it_r != '0) || it_r + 1'b1 >= leff) begin
            last_it_r <= it_r + 1'b1;
            last_conv_r <= same_r && it_r != '0;
            st_r <= S_FIN;
          end else begin
            same_r <= 1'b1; pi_r <= '0; ci_r <= '0;
            st_r <= (total_r == '0) ? S_U_CLR : S_A_RD;
          end
        end
        S_FIN: begin
          res_r <= mk(KIND_DONE, '0, ERR_NONE, last_it_r, last_conv_r);
          res_v_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = res_v_r;
  assign out_item  = res_r;

`ifndef NO_ASSERTIONS
  a_div_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    d_busy |-> (st_r == S_D_WAIT)) else $error("divider busy outside mean step");
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= PC'(MAX_POINTS)) else $error("point total overflow");
  a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN) |=> (out_valid && out_item.kind == KIND_DONE))
    else $error("run finished without result");
`endif
endmodule

### sim/tb_one_d_kmeans_clustering.sv
// Testbench for the 1-D k-means engine: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module tb_one_d_kmeans_clustering;
  import kmeans_pkg::*;

  localparam int NPTS = 1024;
  localparam int NCL  = 16;
  // Commands 6 and 7 have no meaning; the block must ignore them.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  // Cycles to let a result-less command drain before touching registers.
  localparam int DRAIN_CYCLES = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_item = '0;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [9:0] cfg_data = '0;

  one_d_kmeans_clustering dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the stores, the run status and the registers.
  // ---------------------------------------------------------------------------
  logic signed [31:0] pt_mem [NPTS];
  int                 memb_mem [NPTS];
  int                 memb_next [NPTS];
  longint             cent_mem [NCL];
  longint             clus_sum [NCL];
  int                 clus_size [NCL];
  int                 pt_count = 0;
  logic [9:0]         run_iters = '0;
  logic               run_conv = 1'b0;
  logic [4:0]         k_reg = 5'd2;
  logic [9:0]         lim_reg = 10'd255;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int        n_errors = 0;
  int        n_results = 0;
  int        n_runs = 0;
  int        n_cfg = 0;
  int        gap_left = 0;
  bit        no_idle = 1'b0;

  function automatic longint abs_gap(longint a, longint b);
    longint d;
    d = a - b;
    return (d < 0) ? -d : d;
  endfunction

  // Append one expected result behind the ones already owed.
  function automatic void queue_expected(out_item_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // One full run: repeat Lloyd passes until memberships settle or the limit hits.
  task automatic lloyd_run();
    int k, lim, it, best;
    bit conv, same;
    longint bd, d;
    k = (k_reg == 0) ? 1 : ((k_reg > NCL) ? NCL : int'(k_reg));
    lim = (lim_reg == 0) ? 1 : int'(lim_reg);
    it = 0;
    conv = 1'b0;
    while (it < lim && !conv) begin
      same = 1'b1;
      for (int i = 0; i < pt_count; i++) begin
        best = 0;
        bd = abs_gap(cent_mem[0], longint'(pt_mem[i]));
        for (int j = 1; j < k; j++) begin
          d = abs_gap(cent_mem[j], longint'(pt_mem[i]));
          if (d < bd) begin
            bd = d;
            best = j;
          end
        end
        memb_next[i] = best;
      end
      for (int i = 0; i < pt_count; i++) begin
        if (memb_next[i] != memb_mem[i]) same = 1'b0;
        memb_mem[i] = memb_next[i];
      end
      for (int j = 0; j < k; j++) begin
        clus_sum[j] = 0;
        clus_size[j] = 0;
      end
      for (int i = 0; i < pt_count; i++) begin
        clus_sum[memb_mem[i]] += longint'(pt_mem[i]);
        clus_size[memb_mem[i]]++;
      end
      // Mean truncates toward zero; an empty cluster collapses to 0.
      for (int j = 0; j < k; j++)
        cent_mem[j] = (clus_size[j] == 0) ? 0 : clus_sum[j] / longint'(clus_size[j]);
      conv = (it > 0) && same;
      it++;
    end
    run_iters = it[9:0];
    run_conv = conv;
  endtask

  function automatic out_item_t make_result(logic [1:0] kind, logic [31:0] data,
                                            logic [1:0] code);
    out_item_t r;
    r.kind = kind;
    r.data = data;
    r.iterations = run_iters;
    r.converged = run_conv;
    r.error_code = code;
    return r;
  endfunction

  // Apply one accepted item to the predictor and queue what it should return.
  task automatic predict_command(in_item_t it);
    case (it.command)
      CMD_LOAD_POINT: begin
        if (pt_count >= NPTS) begin
          queue_expected(make_result(KIND_ERR, '0, ERR_FULL));
        end else begin
          pt_mem[pt_count] = it.value;
          pt_count++;
        end
      end
      CMD_LOAD_CENT: begin
        if (it.slot >= NCL) queue_expected(make_result(KIND_ERR, '0, ERR_RANGE));
        else cent_mem[it.slot] = longint'(it.value);
      end
      CMD_RUN: begin
        lloyd_run();
        n_runs++;
        queue_expected(make_result(KIND_DONE, '0, ERR_NONE));
      end
      CMD_READ_MEMB: begin
        if (it.slot >= pt_count)
          queue_expected(make_result(KIND_ERR, '0, ERR_RANGE));
        else
          queue_expected(make_result(KIND_MEMB, memb_mem[it.slot], ERR_NONE));
      end
      CMD_READ_CENT: begin
        if (it.slot >= NCL)
          queue_expected(make_result(KIND_ERR, '0, ERR_RANGE));
        else
          queue_expected(make_result(KIND_CENT, cent_mem[it.slot][31:0], ERR_NONE));
      end
      CMD_CLEAR: pt_count = 0;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the next pending item, with random gaps between items.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    bit fire;
    if (rst_n) begin
      fire = start && !busy;
      if (fire) predict_command(in_item);
      if (!start || fire) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          start <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Track register writes so the predictor sees them at the handshake edge.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CLUSTERS) k_reg = cfg_data[4:0];
      else lim_reg = cfg_data;
      n_cfg++;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result must match the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d data=%0d", out_item.kind, out_item.data);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
          n_errors++;
        end
        if (out_item.data !== want.data) begin
          $error("data: expected %0d, got %0d", want.data, out_item.data);
          n_errors++;
        end
        if (out_item.iterations !== want.iterations) begin
          $error("iterations: expected %0d, got %0d", want.iterations, out_item.iterations);
          n_errors++;
        end
        if (out_item.converged !== want.converged) begin
          $error("converged: expected %0d, got %0d", want.converged, out_item.converged);
          n_errors++;
        end
        if (out_item.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_item.error_code);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation. Shadow counters keep membership reads off points that
  // no run has assigned yet: slots below assigned_g or at/after total_g only.
  // ---------------------------------------------------------------------------
  int total_g = 0;
  int assigned_g = 0;
  int n_items = 0;

  task automatic add(logic [2:0] cmd, logic [31:0] val, logic [9:0] slot);
    in_item_t it;
    it.command = cmd;
    it.value = val;
    it.slot = slot;
    pending_items.insert(pending_items.size(), it);
    n_items++;
    case (cmd)
      CMD_LOAD_POINT: if (total_g < NPTS) total_g++;
      CMD_RUN: assigned_g = total_g;
      CMD_CLEAR: begin
        total_g = 0;
        assigned_g = 0;
      end
      default: ;
    endcase
  endtask

  // Either any 32-bit value or one near a few cluster centers, so runs move.
  function automatic logic [31:0] rand_value();
    int c;
    if ($urandom_range(0, 3) == 0) return $urandom;
    c = $urandom_range(0, 7) - 4;
    return (c <<< 20) + ($urandom_range(0, 65535) - 32768);
  endfunction

  function automatic logic [9:0] memb_slot();
    if (assigned_g > 0 && $urandom_range(0, 4) != 0) return 10'($urandom_range(0, assigned_g - 1));
    if (total_g < NPTS) return 10'($urandom_range(total_g, NPTS - 1));
    return 10'($urandom_range(0, NPTS - 1));
  endfunction

  // Hold until the driver is empty, every result is in and the block is idle.
  task automatic settle();
    wait (pending_items.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    wait (!busy);
  endtask

  task automatic write_reg(logic idx, logic [9:0] data);
    int seen;
    seen = n_cfg;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    wait (n_cfg != seen);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int npts, kk;
    int r;
    int random_start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset values, empty store, range errors, spare commands, extremes.
    add(CMD_READ_CENT, '0, 10'd0);
    add(CMD_READ_MEMB, '0, 10'd0);
    add(CMD_RUN, '0, '0);
    add(CMD_READ_CENT, '0, 10'd15);
    add(CMD_LOAD_CENT, 32'h1234_5678, 10'd16);
    add(CMD_READ_CENT, '0, 10'd1023);
    add(CMD_SPARE_A, 32'hFFFF_FFFF, 10'd1023);
    add(CMD_SPARE_B, '0, '0);
    add(CMD_LOAD_POINT, 32'h8000_0000, '0);
    add(CMD_LOAD_POINT, 32'h7FFF_FFFF, '0);
    add(CMD_LOAD_POINT, 32'h0000_0000, '0);
    add(CMD_LOAD_CENT, 32'h8000_0000, 10'd0);
    add(CMD_LOAD_CENT, 32'h7FFF_FFFF, 10'd1);
    add(CMD_LOAD_CENT, 32'hFFFF_FFFF, 10'd15);
    add(CMD_RUN, '0, '0);
    for (int i = 0; i < 3; i++) add(CMD_READ_MEMB, '0, 10'(i));
    add(CMD_READ_MEMB, '0, 10'd3);
    add(CMD_READ_CENT, '0, 10'd0);
    add(CMD_READ_CENT, '0, 10'd1);
    add(CMD_READ_CENT, '0, 10'd15);
    add(CMD_CLEAR, '0, '0);
    add(CMD_READ_MEMB, '0, 10'd0);
    add(CMD_RUN, '0, '0);
    settle();

    // A single-iteration run can never report convergence.
    write_reg(CFG_ITERS, 10'd1);
    add(CMD_LOAD_POINT, 32'h0001_0000, '0);
    add(CMD_LOAD_POINT, 32'hFFFF_0000, '0);
    add(CMD_RUN, '0, '0);
    add(CMD_READ_MEMB, '0, 10'd1);
    settle();

    // Fill the point store to the top, then overflow it.
    write_reg(CFG_CLUSTERS, 10'd2);
    add(CMD_CLEAR, '0, '0);
    for (int i = 0; i < NPTS; i++) add(CMD_LOAD_POINT, $urandom, '0);
    add(CMD_LOAD_POINT, 32'h0000_0001, '0);
    add(CMD_LOAD_POINT, 32'hDEAD_BEEF, '0);
    add(CMD_RUN, '0, '0);
    add(CMD_READ_MEMB, '0, 10'd1023);
    add(CMD_READ_MEMB, '0, 10'd0);
    add(CMD_READ_CENT, '0, 10'd1);
    add(CMD_CLEAR, '0, '0);
    settle();

    // Random phases: registers change only between drained phases.
    random_start = n_items;
    while (n_items - random_start < 500) begin
      settle();
      no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) write_reg(CFG_CLUSTERS, 10'd0);
      else if (r == 1) write_reg(CFG_CLUSTERS, 10'd31);
      else if (r == 2) write_reg(CFG_CLUSTERS, 10'd16);
      else if (r == 3) write_reg(CFG_CLUSTERS, 10'($urandom_range(17, 30)));
      else write_reg(CFG_CLUSTERS, 10'($urandom_range(1, 16)));
      r = $urandom_range(0, 9);
      if (r == 0) write_reg(CFG_ITERS, 10'd0);
      else if (r == 1) write_reg(CFG_ITERS, 10'd1023);
      else if (r == 2) write_reg(CFG_ITERS, 10'd1);
      else write_reg(CFG_ITERS, 10'($urandom_range(2, 12)));
      kk = (k_reg == 0) ? 1 : ((k_reg > NCL) ? NCL : int'(k_reg));

      if ($urandom_range(0, 2) == 0 || total_g > 40) add(CMD_CLEAR, '0, '0);
      npts = $urandom_range(0, 20);
      for (int i = 0; i < npts; i++) add(CMD_LOAD_POINT, rand_value(), '0);
      for (int j = 0; j < kk; j++)
        if ($urandom_range(0, 3) != 0) add(CMD_LOAD_CENT, rand_value(), 10'(j));
      if ($urandom_range(0, 2) == 0)
        add(CMD_LOAD_CENT, rand_value(), 10'($urandom_range(0, 1023)));
      if ($urandom_range(0, 4) == 0)
        add(($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B, $urandom, 10'($urandom));
      add(CMD_RUN, '0, '0);
      repeat ($urandom_range(3, 10)) begin
        r = $urandom_range(0, 9);
        if (r < 5) add(CMD_READ_MEMB, $urandom, memb_slot());
        else if (r < 8) add(CMD_READ_CENT, $urandom, 10'($urandom_range(0, NCL - 1)));
        else add(CMD_READ_CENT, $urandom, 10'($urandom_range(0, 1023)));
      end
      // Append unassigned points and keep reading around them.
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 4)) add(CMD_LOAD_POINT, rand_value(), '0);
        repeat (3) add(CMD_READ_MEMB, '0, memb_slot());
      end
    end

    settle();
    repeat (50) @(posedge clk);
    $display("Covered %0d items, %0d runs, %0d results checked, %0d register writes.",
             n_items, n_runs, n_results, n_cfg);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timed out with %0d results still owed.", expected_results.size());
    $display("Some tests failed");
    $finish;
  end
endmodule

### filelist.f
rtl/kmeans_pkg.sv
rtl/kmeans_div.sv
rtl/one_d_kmeans_clustering.sv
sim/tb_one_d_kmeans_clustering.sv
